// File: rtl/pdc_pkg.sv
// Shared types, constants and codes of the 4D vertex projection block.
`timescale 1ns / 1ps
package pdc_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_W = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CUE = 2'd2;

  localparam int DVD_W = 64;
  localparam int DVS_W = 40;
  localparam int QUO_W = 32;

  typedef struct packed {
    logic signed [31:0] orig_x;
    logic signed [31:0] orig_y;
    logic signed [31:0] orig_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_w;
    logic               last_vertex;
  } in_t;

  typedef struct packed {
    logic signed [31:0] scr_x;
    logic signed [31:0] scr_y;
    logic signed [31:0] scr_z;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic               div_fault;
    logic               overflowed;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_w;
  } vtx_t;

  localparam int VTX_W = $bits(vtx_t);

  typedef enum logic [3:0] {
    S_LOAD,
    S_READ,
    S_RDW,
    S_MUL,
    S_PREP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_POST,
    S_PUSH
  } state_t;

  typedef enum logic [2:0] {
    OP_X,
    OP_Y,
    OP_Z,
    OP_R,
    OP_G,
    OP_B
  } op_t;

  typedef struct packed {
    logic load;
    logic read;
    logic latch;
    logic mul;
    logic prep;
    logic div_start;
    logic post;
    logic push;
    logic next_vtx;
    logic finish;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic cue_en;
    logic div_busy;
    logic div_done;
    logic out_free;
    logic last_vtx;
  } sts_t;

endpackage

// File: rtl/pdc_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module pdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pdc_div.sv
// Iterative restoring divider, one quotient bit per cycle, with overflow detect.
`timescale 1ns / 1ps
module pdc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pdc_pkg::DVD_W-1:0]  dvd,
  input  logic [pdc_pkg::DVS_W-1:0]  dvs,
  output logic [pdc_pkg::QUO_W-1:0]  quo,
  output logic                       ovf,
  output logic                       busy,
  output logic                       done
);

  localparam int CW = $clog2(pdc_pkg::QUO_W);
  localparam int RW = pdc_pkg::DVS_W + 1;
  localparam int HW = pdc_pkg::DVD_W - pdc_pkg::QUO_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [pdc_pkg::QUO_W-1:0] q_r, q_nxt;
  logic [pdc_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic          ovf_r, ovf_nxt;
  logic [RW-1:0] rem_sh;
  logic          ge;
  logic          hi_ovf;

  assign hi_ovf = {{(pdc_pkg::DVS_W - HW){1'b0}}, dvd[pdc_pkg::DVD_W-1:pdc_pkg::QUO_W]} >= dvs;
  assign rem_sh = {rem_r[RW-2:0], q_r[pdc_pkg::QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      dvs_nxt = dvs;
      ovf_nxt = hi_ovf;
      rem_nxt = {{(RW - HW){1'b0}}, dvd[pdc_pkg::DVD_W-1:pdc_pkg::QUO_W]};
      q_nxt   = dvd[pdc_pkg::QUO_W-1:0];
      cnt_nxt = '0;
      if (hi_ovf) begin
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      q_nxt   = {q_r[pdc_pkg::QUO_W-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(pdc_pkg::QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
    ovf_r <= ovf_nxt;
  end

  assign quo  = q_r;
  assign ovf  = ovf_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

// File: rtl/pdc_ctrl.sv
// Controller state machine sequencing load, per-vertex arithmetic and result pushes.
`timescale 1ns / 1ps
module pdc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  input  pdc_pkg::sts_t sts,
  output logic          in_stall,
  output pdc_pkg::cmd_t cmd
);

  pdc_pkg::state_t state_r, state_nxt;
  pdc_pkg::op_t    op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      pdc_pkg::S_LOAD: begin
        if (in_valid && in_last) begin
          state_nxt = pdc_pkg::S_READ;
        end
      end
      pdc_pkg::S_READ:   state_nxt = pdc_pkg::S_RDW;
      pdc_pkg::S_RDW: begin
        state_nxt = pdc_pkg::S_MUL;
        op_nxt    = pdc_pkg::OP_X;
      end
      pdc_pkg::S_MUL:    state_nxt = pdc_pkg::S_PREP;
      pdc_pkg::S_PREP:   state_nxt = pdc_pkg::S_DIV_GO;
      pdc_pkg::S_DIV_GO: state_nxt = pdc_pkg::S_DIV_WAIT;
      pdc_pkg::S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = pdc_pkg::S_POST;
        end
      end
      pdc_pkg::S_POST: begin
        if ((op_r == pdc_pkg::OP_Z && !sts.cue_en) || op_r == pdc_pkg::OP_B) begin
          state_nxt = pdc_pkg::S_PUSH;
          op_nxt    = pdc_pkg::OP_X;
        end else begin
          state_nxt = pdc_pkg::S_MUL;
          op_nxt    = pdc_pkg::op_t'(op_r + 3'd1);
        end
      end
      pdc_pkg::S_PUSH: begin
        if (sts.out_free) begin
          state_nxt = sts.last_vtx ? pdc_pkg::S_LOAD : pdc_pkg::S_READ;
        end
      end
      default: state_nxt = pdc_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.op   = op_r;
    in_stall = 1'b1;
    unique case (state_r)
      pdc_pkg::S_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      pdc_pkg::S_READ:     cmd.read = 1'b1;
      pdc_pkg::S_RDW:      cmd.latch = 1'b1;
      pdc_pkg::S_MUL:      cmd.mul = 1'b1;
      pdc_pkg::S_PREP:     cmd.prep = 1'b1;
      pdc_pkg::S_DIV_GO:   cmd.div_start = 1'b1;
      pdc_pkg::S_DIV_WAIT: ;
      pdc_pkg::S_POST:     cmd.post = 1'b1;
      pdc_pkg::S_PUSH: begin
        cmd.push     = sts.out_free;
        cmd.next_vtx = sts.out_free && !sts.last_vtx;
        cmd.finish   = sts.out_free && sts.last_vtx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdc_pkg::S_LOAD;
      op_r    <= pdc_pkg::OP_X;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

// File: rtl/pdc_dp.sv
// Datapath: vertex store, set extremes, multiplier, divider and result registers.
`timescale 1ns / 1ps
module pdc_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  pdc_pkg::in_t                     in_data,
  input  pdc_pkg::cmd_t                    cmd,
  output pdc_pkg::sts_t                    sts,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pdc_pkg::out_t                    out_data
);

  localparam int CNT_W = pdc_pkg::CNT_W;
  localparam int IDX_W = pdc_pkg::IDX_W;

  logic signed [31:0] screen_w_r, camera_w_r;
  logic               cue_on_r;

  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   emit_r;
  logic signed [31:0] wmin_r, wmax_r;
  logic               ovf_seen_r;

  logic [32:0]        d_r;
  logic signed [32:0] numc_r;
  logic [39:0]        den100_r;
  logic [52:0]        k_r;

  pdc_pkg::vtx_t      v_r, wr_vtx, rd_vtx;
  logic [pdc_pkg::VTX_W-1:0] rdata;
  logic               ram_we;

  logic signed [32:0] den_r;
  logic [36:0]        e_r;
  logic signed [64:0] prod_r;
  logic [63:0]        dvd_r;
  logic [39:0]        dvs_r;
  logic               sgn_r, zden_r, pzero_r, pneg_r, cneg_r;

  pdc_pkg::out_t      res_r, out_r;
  logic               out_valid_r;

  logic [31:0]        quo;
  logic               dovf, dbusy, ddone;

  logic [15:0]        csel;
  logic signed [21:0] cterm;
  logic signed [32:0] op_a;
  logic signed [37:0] op_b;
  logic signed [70:0] mprod;
  logic signed [31:0] psel;
  logic [32:0]        a_w;
  logic [64:0]        pabs;
  logic [32:0]        dabs;
  logic signed [64:0] csum;
  logic [31:0]        proj_val;
  logic [15:0]        cue_val;
  logic [32:0]        dw;

  function automatic logic [15:0] base_colour(input logic signed [31:0] c);
    logic signed [32:0] t;
    t = {c[31], c} + 33'sd65536;
    if (t[32]) begin
      return 16'd0;
    end else if (t[31:17] != '0) begin
      return 16'hFFFF;
    end else begin
      return t[16:1];
    end
  endfunction

  assign ram_we = cmd.load && (count_r < CNT_W'(pdc_pkg::MAX_VERTICES));

  always_comb begin
    wr_vtx.red   = base_colour(in_data.orig_x);
    wr_vtx.green = base_colour(in_data.orig_y);
    wr_vtx.blue  = base_colour(in_data.orig_z);
    wr_vtx.pos_x = in_data.pos_x;
    wr_vtx.pos_y = in_data.pos_y;
    wr_vtx.pos_z = in_data.pos_z;
    wr_vtx.pos_w = in_data.pos_w;
  end

  pdc_ram #(
    .WIDTH (pdc_pkg::VTX_W),
    .DEPTH (pdc_pkg::MAX_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_vtx),
    .raddr (emit_r),
    .rdata (rdata)
  );

  assign rd_vtx = pdc_pkg::vtx_t'(rdata);

  pdc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .dvd   (dvd_r),
    .dvs   (dvs_r),
    .quo   (quo),
    .ovf   (dovf),
    .busy  (dbusy),
    .done  (ddone)
  );

  // Configuration and set bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= '0;
      camera_w_r <= -32'sd196608;
      cue_on_r   <= 1'b0;
      count_r    <= '0;
      emit_r     <= '0;
      wmin_r     <= '0;
      wmax_r     <= '0;
      ovf_seen_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pdc_pkg::CFG_SCREEN_W:  screen_w_r <= cfg_data;
          pdc_pkg::CFG_CAMERA_W:  camera_w_r <= cfg_data;
          pdc_pkg::CFG_DEPTH_CUE: cue_on_r <= cfg_data[0];
          default:                cue_on_r <= cue_on_r;
        endcase
      end
      if (cmd.load) begin
        if (ram_we) begin
          count_r <= count_r + CNT_W'(1);
          if (count_r == '0 || in_data.pos_w < wmin_r) begin
            wmin_r <= in_data.pos_w;
          end
          if (count_r == '0 || in_data.pos_w > wmax_r) begin
            wmax_r <= in_data.pos_w;
          end
        end else begin
          ovf_seen_r <= 1'b1;
        end
      end
      if (cmd.next_vtx) begin
        emit_r <= emit_r + IDX_W'(1);
      end
      if (cmd.finish) begin
        count_r    <= '0;
        emit_r     <= '0;
        wmin_r     <= '0;
        wmax_r     <= '0;
        ovf_seen_r <= 1'b0;
      end
    end
  end

  assign dw = 33'({wmax_r[31], wmax_r} - {wmin_r[31], wmin_r});

  // Per-set constants, taken when the emit phase reads each vertex.
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      d_r      <= dw;
      numc_r   <= {screen_w_r[31], screen_w_r} - {camera_w_r[31], camera_w_r};
      den100_r <= ({7'b0, dw} << 6) + ({7'b0, dw} << 5) + ({7'b0, dw} << 2);
      k_r      <= ({20'b0, dw} << 19) + ({20'b0, dw} << 17) + ({20'b0, dw} << 5)
                + ({20'b0, dw} << 4) + ({20'b0, dw} << 1);
    end
  end

  always_comb begin
    unique case (cmd.op)
      pdc_pkg::OP_X: psel = v_r.pos_x;
      pdc_pkg::OP_Y: psel = v_r.pos_y;
      default:       psel = v_r.pos_z;
    endcase
    unique case (cmd.op)
      pdc_pkg::OP_R: csel = v_r.red;
      pdc_pkg::OP_G: csel = v_r.green;
      default:       csel = v_r.blue;
    endcase
    cterm = $signed({6'b0, csel} << 3) + $signed({6'b0, csel} << 1) - 22'sd65536;
    if (cmd.op == pdc_pkg::OP_X || cmd.op == pdc_pkg::OP_Y || cmd.op == pdc_pkg::OP_Z) begin
      op_a = {psel[31], psel};
      op_b = {{5{numc_r[32]}}, numc_r};
    end else begin
      op_a = {{11{cterm[21]}}, cterm};
      op_b = {1'b0, e_r};
    end
    mprod = op_a * op_b;
    a_w   = 33'({wmax_r[31], wmax_r} - {v_r.pos_w[31], v_r.pos_w});
    pabs  = prod_r[64] ? 65'(-prod_r) : 65'(prod_r);
    dabs  = den_r[32] ? 33'(-den_r) : 33'(den_r);
    csum  = $signed({12'b0, k_r}) + prod_r;
  end

  always_comb begin
    if (zden_r) begin
      proj_val = pzero_r ? 32'd0 : (pneg_r ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end else if (!sgn_r) begin
      proj_val = (dovf || quo[31]) ? 32'h7FFF_FFFF : quo;
    end else begin
      proj_val = (dovf || quo > 32'h8000_0000) ? 32'h8000_0000 : 32'(-quo);
    end
    if (cneg_r) begin
      cue_val = 16'd0;
    end else if (dovf || quo[31:16] != '0) begin
      cue_val = 16'hFFFF;
    end else begin
      cue_val = quo[15:0];
    end
  end

  // Arithmetic pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      v_r               <= rd_vtx;
      res_r.red         <= rd_vtx.red;
      res_r.green       <= rd_vtx.green;
      res_r.blue        <= rd_vtx.blue;
      res_r.overflowed  <= ovf_seen_r;
      res_r.last_result <= sts.last_vtx;
    end
    if (cmd.mul) begin
      prod_r <= mprod[64:0];
      if (cmd.op == pdc_pkg::OP_X) begin
        den_r <= {v_r.pos_w[31], v_r.pos_w} - {camera_w_r[31], camera_w_r};
        e_r   <= {4'b0, d_r} + ({4'b0, a_w} << 3) + {4'b0, a_w};
      end
    end
    if (cmd.prep) begin
      if (cmd.op == pdc_pkg::OP_X || cmd.op == pdc_pkg::OP_Y || cmd.op == pdc_pkg::OP_Z) begin
        dvd_r   <= pabs[63:0];
        dvs_r   <= {7'b0, dabs};
        sgn_r   <= prod_r[64] ^ den_r[32];
        zden_r  <= den_r == '0;
        pzero_r <= prod_r == '0;
        pneg_r  <= prod_r[64];
        cneg_r  <= 1'b0;
      end else begin
        dvd_r   <= csum[63:0];
        dvs_r   <= den100_r;
        sgn_r   <= 1'b0;
        zden_r  <= 1'b0;
        pzero_r <= 1'b0;
        pneg_r  <= 1'b0;
        cneg_r  <= csum[64];
      end
    end
    if (cmd.post) begin
      unique case (cmd.op)
        pdc_pkg::OP_X: begin
          res_r.scr_x     <= proj_val;
          res_r.div_fault <= zden_r;
        end
        pdc_pkg::OP_Y: res_r.scr_y <= proj_val;
        pdc_pkg::OP_Z: res_r.scr_z <= proj_val;
        pdc_pkg::OP_R: res_r.red <= cue_val;
        pdc_pkg::OP_G: res_r.green <= cue_val;
        default:       res_r.blue <= cue_val;
      endcase
    end
    if (cmd.push) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.cue_en   = cue_on_r && (d_r != '0);
  assign sts.div_busy = dbusy;
  assign sts.div_done = ddone;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.last_vtx = (CNT_W'(emit_r) + CNT_W'(1)) == count_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/project_4d_vertices_depth_cue_top.sv
// Top level of the 4D vertex projection block with depth cueing.
//
// Vertices arrive as requests on the in_ channel (in_valid / in_stall). While
// a set is loading, one request is taken per cycle; up to MAX_VERTICES are
// stored, later ones are dropped and mark the set overflowed. The last_vertex
// request closes the set; in_stall then rises for the whole emit phase and
// drops again once the last result has been handed over. For each stored vertex,
// in load order, one result request leaves on the out_ channel. Each vertex
// runs three projection divisions and, with depth cueing active on a set with
// spread in w, three more colour divisions, all on one shared divider that
// produces one quotient bit per cycle. Each division step runs multiply,
// operand prep, divider start, the divider bit steps until done, and write
// back; each vertex also passes a store read, a read wait and hand-over.
// A result waits in an output register while out_stall is high; the next
// vertex is already being worked on and holds at hand-over until it drains.
// Configuration (cfg_we / cfg_index / cfg_data) must be written only when idle; the block does not enforce this.
// Reset (rst_n low, synchronous) empties the set, drops any pending result
// and restores screen_w 0, camera_w -3.0 and depth cueing off.
`timescale 1ns / 1ps
module project_4d_vertices_depth_cue_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pdc_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pdc_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pdc_pkg::cmd_t cmd;
  pdc_pkg::sts_t sts;

  pdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_vertex),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  pdc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.out_free)
    else $error("Result pushed into a full output register.");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("Divider restarted while busy.");

  a_load_no_div: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !sts.div_busy)
    else $error("Vertex accepted while a division is running.");
`endif

endmodule

// File: sim/tb_project_4d_vertices_depth_cue_top.sv
// Self-checking testbench of the 4D vertex projection block with depth cueing.
`timescale 1ns / 1ps
module tb_project_4d_vertices_depth_cue_top;

  localparam int SETTLE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TARGET_ITEMS = 320;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  pdc_pkg::in_t                   in_data;
  logic                           out_valid;
  logic                           out_stall;
  pdc_pkg::out_t                  out_data;
  logic                           cfg_we;
  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data;

  project_4d_vertices_depth_cue_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Copy of the block state used to predict the projected vertices.
  logic [15:0] mdl_red [pdc_pkg::MAX_VERTICES];
  logic [15:0] mdl_green [pdc_pkg::MAX_VERTICES];
  logic [15:0] mdl_blue [pdc_pkg::MAX_VERTICES];
  int          mdl_x [pdc_pkg::MAX_VERTICES];
  int          mdl_y [pdc_pkg::MAX_VERTICES];
  int          mdl_z [pdc_pkg::MAX_VERTICES];
  int          mdl_w [pdc_pkg::MAX_VERTICES];
  int          mdl_count;
  int          mdl_wmax;
  int          mdl_wmin;
  bit          mdl_dropped;
  int          mdl_screen_w;
  int          mdl_camera_w;
  bit          mdl_cue_on;

  pdc_pkg::out_t projected_q[$];
  int          errors;
  int          items_sent;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          hold_request;
  int          hold_left;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  function automatic logic [15:0] base_colour(int c);
    longint t;
    t = longint'(c) + 65536;
    if (t < 0) return 16'd0;
    t = t / 2;
    return (t > 65535) ? 16'hFFFF : t[15:0];
  endfunction

  function automatic int sat_word(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  function automatic int project_coord(int p, longint num, longint den);
    longint prod;
    prod = longint'(p) * num;
    if (den == 0) begin
      if (prod == 0) return 0;
      return (prod > 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    return sat_word(prod / den);
  endfunction

  function automatic logic [15:0] dim_colour(logic [15:0] c, longint a, longint d);
    longint num;
    longint den;
    longint r;
    if (d <= 0) return c;
    num = 655360 * d + (10 * longint'(c) - 65536) * (d + 9 * a);
    den = 100 * d;
    if (num < 0) return 16'd0;
    r = (num + den / 2) / den;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic void load_vertex(pdc_pkg::in_t v);
    longint num;
    longint range;
    longint den;
    longint a;
    pdc_pkg::out_t o;
    if (mdl_count < pdc_pkg::MAX_VERTICES) begin
      mdl_red[mdl_count] = base_colour(v.orig_x);
      mdl_green[mdl_count] = base_colour(v.orig_y);
      mdl_blue[mdl_count] = base_colour(v.orig_z);
      mdl_x[mdl_count] = v.pos_x;
      mdl_y[mdl_count] = v.pos_y;
      mdl_z[mdl_count] = v.pos_z;
      mdl_w[mdl_count] = v.pos_w;
      if (mdl_count == 0 || v.pos_w < mdl_wmin) mdl_wmin = v.pos_w;
      if (mdl_count == 0 || v.pos_w > mdl_wmax) mdl_wmax = v.pos_w;
      mdl_count++;
    end else begin
      mdl_dropped = 1'b1;
    end
    if (!v.last_vertex) return;
    num = longint'(mdl_screen_w) - longint'(mdl_camera_w);
    range = longint'(mdl_wmax) - longint'(mdl_wmin);
    for (int i = 0; i < mdl_count; i++) begin
      den = longint'(mdl_w[i]) - longint'(mdl_camera_w);
      a = longint'(mdl_wmax) - longint'(mdl_w[i]);
      o.scr_x = project_coord(mdl_x[i], num, den);
      o.scr_y = project_coord(mdl_y[i], num, den);
      o.scr_z = project_coord(mdl_z[i], num, den);
      o.red = mdl_cue_on ? dim_colour(mdl_red[i], a, range) : mdl_red[i];
      o.green = mdl_cue_on ? dim_colour(mdl_green[i], a, range) : mdl_green[i];
      o.blue = mdl_cue_on ? dim_colour(mdl_blue[i], a, range) : mdl_blue[i];
      o.div_fault = (den == 0);
      o.overflowed = mdl_dropped;
      o.last_result = (i + 1 == mdl_count);
      projected_q.insert(projected_q.size(), o);
    end
    mdl_count = 0;
    mdl_wmax = 0;
    mdl_wmin = 0;
    mdl_dropped = 1'b0;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    pdc_pkg::out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (projected_q.size() == 0) begin
        $error("unexpected result: scr_x %0d", out_data.scr_x);
        errors++;
      end else begin
        e = projected_q.pop_front();
        check_field("scr_x", e.scr_x, out_data.scr_x);
        check_field("scr_y", e.scr_y, out_data.scr_y);
        check_field("scr_z", e.scr_z, out_data.scr_z);
        check_field("red", e.red, out_data.red);
        check_field("green", e.green, out_data.green);
        check_field("blue", e.blue, out_data.blue);
        check_field("div_fault", e.div_fault, out_data.div_fault);
        check_field("overflowed", e.overflowed, out_data.overflowed);
        check_field("last_result", e.last_result, out_data.last_result);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_vertex(pdc_pkg::in_t v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (in_stall);
    load_vertex(v);
    items_sent++;
  endtask

  task automatic end_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    end_sending();
    while (projected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [pdc_pkg::CFG_IDX_W-1:0] idx,
                           logic [pdc_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pdc_pkg::CFG_SCREEN_W: mdl_screen_w = val;
      pdc_pkg::CFG_CAMERA_W: mdl_camera_w = val;
      pdc_pkg::CFG_DEPTH_CUE: mdl_cue_on = val[0];
      default: ;
    endcase
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return int'($urandom_range(8 * 65536)) - 4 * 65536;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return int'($urandom_range(4 * 65536)) - 2 * 65536;
    endcase
  endfunction

  function automatic pdc_pkg::in_t rand_vertex(bit last);
    pdc_pkg::in_t v;
    v.orig_x = rand_coord();
    v.orig_y = rand_coord();
    v.orig_z = rand_coord();
    v.pos_x = rand_coord();
    v.pos_y = rand_coord();
    v.pos_z = rand_coord();
    case ($urandom_range(5))
      0: v.pos_w = mdl_camera_w;
      1: v.pos_w = $urandom;
      default: v.pos_w = int'($urandom_range(6 * 65536)) - 3 * 65536;
    endcase
    v.last_vertex = last;
    return v;
  endfunction

  task automatic send_random_set(int n);
    for (int i = 0; i < n; i++) send_vertex(rand_vertex(i == n - 1));
  endtask

  function automatic pdc_pkg::in_t make_vertex(int ox, int oy, int oz, int px, int py,
                                               int pz, int pw, bit last);
    pdc_pkg::in_t v;
    v.orig_x = ox; v.orig_y = oy; v.orig_z = oz;
    v.pos_x = px; v.pos_y = py; v.pos_z = pz; v.pos_w = pw;
    v.last_vertex = last;
    return v;
  endfunction

  task automatic test_extremes();
    send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF,
                            32'h8000_0000, 0, 32'h7FFF_FFFF, 1'b0));
    send_vertex(make_vertex(65536, -65536, 65535, 65536, -65536, 1, 0, 1'b0));
    send_vertex(make_vertex(-65537, 65537, 1, -1, 1, 32'h8000_0000,
                            32'h8000_0000, 1'b0));
    send_vertex(make_vertex(0, 0, 0, 65536, 65536, 65536, mdl_camera_w, 1'b1));
    wait_drained();
    write_reg(pdc_pkg::CFG_DEPTH_CUE, 32'd1);
    write_reg(pdc_pkg::CFG_SCREEN_W, 32'h7FFF_FFFF);
    write_reg(pdc_pkg::CFG_CAMERA_W, 32'h8000_0000);
    send_vertex(make_vertex(32'h7FFF_FFFF, 0, -65536, 32'h7FFF_FFFF, 32'h8000_0000,
                            1, 32'h7FFF_FFFF, 1'b0));
    send_vertex(make_vertex(0, 65536, 32'h8000_0000, -1, 2, 3, 32'h8000_0000, 1'b0));
    send_vertex(make_vertex(16384, -16384, 32768, 65536, 65536, 65536, 0, 1'b1));
    wait_drained();
  endtask

  task automatic test_single_and_flat();
    write_reg(pdc_pkg::CFG_SCREEN_W, 32'd0);
    write_reg(pdc_pkg::CFG_CAMERA_W, 32'hFFFD_0000);
    send_vertex(make_vertex(65536, 0, -65536, 65536, -65536, 131072, 65536, 1'b1));
    for (int i = 0; i < 3; i++) begin
      send_vertex(make_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), 131072, i == 2));
    end
    wait_drained();
  endtask

  task automatic test_div_fault();
    write_reg(pdc_pkg::CFG_SCREEN_W, 32'h0001_0000);
    write_reg(pdc_pkg::CFG_CAMERA_W, 32'h0001_0000);
    send_vertex(make_vertex(0, 0, 0, 0, 5, -5, 32'h0001_0000, 1'b0));
    send_vertex(make_vertex(0, 0, 0, 7, 0, -7, 32'h0002_0000, 1'b1));
    wait_drained();
    write_reg(pdc_pkg::CFG_SCREEN_W, 32'h0003_0000);
    send_vertex(make_vertex(0, 0, 0, 0, 5, -5, 32'h0001_0000, 1'b0));
    send_vertex(make_vertex(0, 0, 0, 7, 0, -7, 32'h0001_0000, 1'b1));
    wait_drained();
  endtask

  task automatic test_overflow();
    send_random_set(pdc_pkg::MAX_VERTICES + 2);
    wait_drained();
    send_random_set(pdc_pkg::MAX_VERTICES);
    wait_drained();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_random_set(pdc_pkg::MAX_VERTICES);
    hold_request = 3000;
    send_random_set(4);
    wait_drained();
  endtask

  task automatic test_random();
    int phase;
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 59; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 59; end
        default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
      endcase
      if ($urandom_range(2) == 0) begin
        wait_drained();
        case ($urandom_range(2))
          0: write_reg(pdc_pkg::CFG_SCREEN_W, rand_coord());
          1: write_reg(pdc_pkg::CFG_CAMERA_W, rand_coord());
          default: write_reg(pdc_pkg::CFG_DEPTH_CUE, $urandom_range(1));
        endcase
      end
      send_random_set(($urandom_range(9) == 0)
                      ? pdc_pkg::MAX_VERTICES + $urandom_range(1, 3)
                      : $urandom_range(1, 12));
      phase++;
    end
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    errors = 0;
    items_sent = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    quiet_cycles = 0;
    mdl_count = 0;
    mdl_wmax = 0;
    mdl_wmin = 0;
    mdl_dropped = 1'b0;
    mdl_screen_w = 0;
    mdl_camera_w = 32'hFFFD_0000;
    mdl_cue_on = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_single_and_flat();
    test_div_fault();
    write_reg(pdc_pkg::CFG_DEPTH_CUE, 32'd0);
    test_overflow();
    write_reg(pdc_pkg::CFG_DEPTH_CUE, 32'd1);
    test_backpressure();
    test_random();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && projected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
